// ===== hw/rtl/tdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg: shared types and constants of the sorted deadline timer queue
// Queue sizing, command/status codes, sequencer states and the slot index
// helper used by the sequencer.
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DL_W        = 64;
  localparam int MIN_W       = 32;
  localparam int OUT_ID_W    = 8;
  localparam int CFG_W       = 32;
  localparam int ALU_W       = DL_W + 1;

  localparam logic [MIN_W-1:0] MIN_INTERVAL_RESET = MIN_W'(10000);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DEL = 2'd1,
    CMD_EXP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_DUP       = 2'd3
  } stat_t;

  typedef enum logic {
    CFG_MIN_INTERVAL = 1'b0,
    CFG_ONESHOT      = 1'b1
  } cfg_reg_t;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [ID_BITS-1:0] id;
    logic [DL_W-1:0]    dl;
  } mem_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHU_RD,
    ST_SHU_WR,
    ST_SHD_RD,
    ST_SHD_WR,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_ARM_RD,
    ST_ARM_CMP,
    ST_ARM_SUB
  } st_t;

  // logical queue position -> physical slot, ring starting at head
  function automatic logic [IDX_W-1:0] slot_of(input logic [CNT_W-1:0] pos,
                                               input logic [IDX_W-1:0] head);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/tdq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_mem: timer slot storage
// One write port and one registered read port holding id and deadline of
// every slot.
// ----------------------------------------------------------------------------
module tdq_mem (
  input  logic                               clk,
  input  tdq_pkg::mem_wr_t                   wr,
  input  logic [tdq_pkg::IDX_W-1:0]          rd_addr,
  output logic [tdq_pkg::ID_BITS-1:0]        rd_id,
  output logic [tdq_pkg::DL_W-1:0]           rd_dl
);

  logic [tdq_pkg::ID_BITS-1:0] id_mem [tdq_pkg::QUEUE_DEPTH];
  logic [tdq_pkg::DL_W-1:0]    dl_mem [tdq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      id_mem[wr.addr] <= wr.id;
      dl_mem[wr.addr] <= wr.dl;
    end
  end

  always_ff @(posedge clk) begin
    rd_id <= id_mem[rd_addr];
    rd_dl <= dl_mem[rd_addr];
  end

endmodule

// ===== hw/rtl/tdq_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_alu: shared 65-bit add/subtract unit
// Serves deadline compares, the now + min_interval sum and the interval
// subtraction; borrow flags a < b on a subtract.
// ----------------------------------------------------------------------------
module tdq_alu (
  input  tdq_pkg::alu_req_t               req,
  output logic [tdq_pkg::ALU_W-1:0]       res,
  output logic                            borrow
);

  logic [tdq_pkg::ALU_W:0] sum;
  logic                    is_sub;

  assign is_sub = (req.op == tdq_pkg::ALU_SUB);

  always_comb begin
    sum = {1'b0, req.a} + {1'b0, (is_sub ? ~req.b : req.b)}
        + (tdq_pkg::ALU_W+1)'(is_sub);
  end

  assign res    = sum[tdq_pkg::ALU_W-1:0];
  assign borrow = is_sub & ~sum[tdq_pkg::ALU_W];

endmodule

// ===== hw/rtl/sorted_deadline_timer_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_top: sorted one-shot timer queue
// Sequencer around a ring of timer slots and one shared add/subtract unit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the completion result. Results appear for one cycle each on out_*
// with out_valid and cannot be held off. With n pending timers and p the
// position of the entry added or removed, an add scans all n entries, shifts
// the entries from p onward up by one slot and writes the new one; a delete
// scans all n entries and shifts the entries behind p down by one; an expire
// checks the head until it is empty or not yet due. A scan step is one memory
// read and one compare in the shared adder. No clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [7:0]                    in_timer_id,
  input  logic [63:0]                   in_deadline,
  input  logic [63:0]                   in_now,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [7:0]                    out_expired_id,
  output logic [1:0]                    out_status,
  output logic                          out_arm_valid,
  output logic [63:0]                   out_arm_interval,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [tdq_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int IdW  = tdq_pkg::ID_BITS;
  localparam int CntW = tdq_pkg::CNT_W;
  localparam int IdxW = tdq_pkg::IDX_W;
  localparam int DlW  = tdq_pkg::DL_W;
  localparam int MinW = tdq_pkg::MIN_W;
  localparam int AluW = tdq_pkg::ALU_W;
  localparam int OIdW = tdq_pkg::OUT_ID_W;

  tdq_pkg::st_t          state_r, state_nxt;
  tdq_pkg::cmd_t         cmd_r, cmd_nxt;
  tdq_pkg::stat_t        status_r, status_nxt;
  logic [IdW-1:0]        id_r, id_nxt;
  logic [DlW-1:0]        dl_r, dl_nxt;
  logic [DlW-1:0]        now_r, now_nxt;
  logic [DlW-1:0]        hd_r, hd_nxt;
  logic [AluW-1:0]       sum_r, sum_nxt;
  logic [CntW-1:0]       idx_r, idx_nxt;
  logic [CntW-1:0]       pos_r, pos_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic [IdxW-1:0]       head_r, head_nxt;
  logic                  found_r, found_nxt;

  logic [MinW-1:0]       min_r;
  logic                  oneshot_r;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic [OIdW-1:0]       out_id_r, out_id_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic                  out_arm_r, out_arm_nxt;
  logic [DlW-1:0]        out_int_r, out_int_nxt;
  logic                  out_last_r, out_last_nxt;

  tdq_pkg::mem_wr_t      mem_wr;
  logic [IdxW-1:0]       rd_addr;
  logic [IdW-1:0]        rd_id;
  logic [DlW-1:0]        rd_dl;

  tdq_pkg::alu_req_t     alu_req;
  logic [AluW-1:0]       alu_res;
  logic                  alu_borrow;

  logic [CntW-1:0]       idx_inc;
  logic [CntW-1:0]       idx_dec;

  tdq_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_dl   (rd_dl)
  );

  tdq_alu u_alu (
    .req    (alu_req),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign idx_inc = idx_r + CntW'(1);
  assign idx_dec = idx_r - CntW'(1);
  assign busy    = (state_r != tdq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= tdq_pkg::MIN_INTERVAL_RESET;
      oneshot_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (tdq_pkg::cfg_reg_t'(cfg_index))
        tdq_pkg::CFG_MIN_INTERVAL: min_r     <= cfg_wdata[MinW-1:0];
        tdq_pkg::CFG_ONESHOT:      oneshot_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdq_pkg::ST_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    id_r         <= id_nxt;
    dl_r         <= dl_nxt;
    now_r        <= now_nxt;
    hd_r         <= hd_nxt;
    sum_r        <= sum_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_arm_r    <= out_arm_nxt;
    out_int_r    <= out_int_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    id_nxt         = id_r;
    dl_nxt         = dl_r;
    now_nxt        = now_r;
    hd_nxt         = hd_r;
    sum_nxt        = sum_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    found_nxt      = found_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_arm_nxt    = out_arm_r;
    out_int_nxt    = out_int_r;
    out_last_nxt   = out_last_r;
    mem_wr.en      = 1'b0;
    mem_wr.addr    = tdq_pkg::slot_of(idx_r, head_r);
    mem_wr.id      = rd_id;
    mem_wr.dl      = rd_dl;
    rd_addr        = tdq_pkg::slot_of(idx_r, head_r);
    alu_req.op     = tdq_pkg::ALU_SUB;
    alu_req.a      = {1'b0, dl_r};
    alu_req.b      = {1'b0, rd_dl};

    unique case (state_r)
      tdq_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt    = tdq_pkg::cmd_t'(in_cmd);
          id_nxt     = IdW'(in_timer_id);
          dl_nxt     = in_deadline;
          now_nxt    = in_now;
          idx_nxt    = '0;
          pos_nxt    = cnt_r;
          found_nxt  = 1'b0;
          status_nxt = tdq_pkg::STAT_OK;
          unique case (tdq_pkg::cmd_t'(in_cmd))
            tdq_pkg::CMD_ADD, tdq_pkg::CMD_DEL: state_nxt = tdq_pkg::ST_SCAN_RD;
            tdq_pkg::CMD_EXP:                   state_nxt = tdq_pkg::ST_EXP_RD;
            default:                            state_nxt = tdq_pkg::ST_ARM_RD;
          endcase
        end
      end

      tdq_pkg::ST_SCAN_RD: begin
        if (idx_r != cnt_r) begin
          state_nxt = tdq_pkg::ST_SCAN_CHK;
        end else if (cmd_r == tdq_pkg::CMD_ADD) begin
          if (found_r) begin
            status_nxt = tdq_pkg::STAT_DUP;
            state_nxt  = tdq_pkg::ST_ARM_RD;
          end else if (cnt_r == CntW'(tdq_pkg::QUEUE_DEPTH)) begin
            status_nxt = tdq_pkg::STAT_FULL;
            state_nxt  = tdq_pkg::ST_ARM_RD;
          end else begin
            idx_nxt   = cnt_r;
            state_nxt = tdq_pkg::ST_SHU_RD;
          end
        end else begin
          if (!found_r) begin
            status_nxt = tdq_pkg::STAT_NOT_FOUND;
            state_nxt  = tdq_pkg::ST_ARM_RD;
          end else begin
            idx_nxt   = pos_r;
            state_nxt = tdq_pkg::ST_SHD_RD;
          end
        end
      end

      tdq_pkg::ST_SCAN_CHK: begin
        // borrow: slot deadline later than the new one
        if (rd_id == id_r) begin
          found_nxt = 1'b1;
          if (cmd_r == tdq_pkg::CMD_DEL) begin
            pos_nxt = idx_r;
          end
        end
        if (cmd_r == tdq_pkg::CMD_ADD && alu_borrow && pos_r == cnt_r) begin
          pos_nxt = idx_r;
        end
        idx_nxt   = idx_inc;
        state_nxt = tdq_pkg::ST_SCAN_RD;
      end

      tdq_pkg::ST_SHU_RD: begin
        if (idx_r == pos_r) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = tdq_pkg::slot_of(pos_r, head_r);
          mem_wr.id   = id_r;
          mem_wr.dl   = dl_r;
          cnt_nxt     = cnt_r + CntW'(1);
          state_nxt   = tdq_pkg::ST_ARM_RD;
        end else begin
          rd_addr   = tdq_pkg::slot_of(idx_dec, head_r);
          state_nxt = tdq_pkg::ST_SHU_WR;
        end
      end

      tdq_pkg::ST_SHU_WR: begin
        mem_wr.en = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = tdq_pkg::ST_SHU_RD;
      end

      tdq_pkg::ST_SHD_RD: begin
        if (idx_inc == cnt_r) begin
          cnt_nxt   = cnt_r - CntW'(1);
          state_nxt = tdq_pkg::ST_ARM_RD;
        end else begin
          rd_addr   = tdq_pkg::slot_of(idx_inc, head_r);
          state_nxt = tdq_pkg::ST_SHD_WR;
        end
      end

      tdq_pkg::ST_SHD_WR: begin
        mem_wr.en = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = tdq_pkg::ST_SHD_RD;
      end

      tdq_pkg::ST_EXP_RD: begin
        rd_addr = head_r;
        if (cnt_r == '0) begin
          state_nxt = tdq_pkg::ST_ARM_RD;
        end else begin
          state_nxt = tdq_pkg::ST_EXP_CHK;
        end
      end

      tdq_pkg::ST_EXP_CHK: begin
        alu_req.a = {1'b0, now_r};
        if (!alu_borrow) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = tdq_pkg::KIND_NOTICE;
          out_id_nxt     = OIdW'(rd_id);
          out_status_nxt = tdq_pkg::STAT_OK;
          out_arm_nxt    = 1'b0;
          out_int_nxt    = '0;
          out_last_nxt   = 1'b0;
          head_nxt       = tdq_pkg::slot_of(CntW'(1), head_r);
          cnt_nxt        = cnt_r - CntW'(1);
          state_nxt      = tdq_pkg::ST_EXP_RD;
        end else begin
          state_nxt = tdq_pkg::ST_ARM_RD;
        end
      end

      tdq_pkg::ST_ARM_RD: begin
        rd_addr    = head_r;
        alu_req.op = tdq_pkg::ALU_ADD;
        alu_req.a  = {1'b0, now_r};
        alu_req.b  = AluW'(min_r);
        if (oneshot_r && cnt_r != '0) begin
          sum_nxt   = alu_res;
          state_nxt = tdq_pkg::ST_ARM_CMP;
        end else begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = tdq_pkg::KIND_DONE;
          out_id_nxt     = OIdW'(id_r);
          out_status_nxt = status_r;
          out_arm_nxt    = 1'b0;
          out_int_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = tdq_pkg::ST_IDLE;
        end
      end

      tdq_pkg::ST_ARM_CMP: begin
        // borrow: head deadline later than now + min_interval
        alu_req.a = sum_r;
        if (alu_borrow) begin
          hd_nxt    = rd_dl;
          state_nxt = tdq_pkg::ST_ARM_SUB;
        end else begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = tdq_pkg::KIND_DONE;
          out_id_nxt     = OIdW'(id_r);
          out_status_nxt = status_r;
          out_arm_nxt    = 1'b1;
          out_int_nxt    = DlW'(min_r);
          out_last_nxt   = 1'b1;
          state_nxt      = tdq_pkg::ST_IDLE;
        end
      end

      tdq_pkg::ST_ARM_SUB: begin
        alu_req.a      = {1'b0, hd_r};
        alu_req.b      = {1'b0, now_r};
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = tdq_pkg::KIND_DONE;
        out_id_nxt     = OIdW'(id_r);
        out_status_nxt = status_r;
        out_arm_nxt    = 1'b1;
        out_int_nxt    = alu_res[DlW-1:0];
        out_last_nxt   = 1'b1;
        state_nxt      = tdq_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = tdq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_expired_id   = out_id_r;
  assign out_status       = out_status_r;
  assign out_arm_valid    = out_arm_r;
  assign out_arm_interval = out_int_r;
  assign out_last         = out_last_r;

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but sequencer not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tdq_pkg::KIND_DONE |-> !busy)
    else $error("completion while sequencer still busy");

  a_notice_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tdq_pkg::KIND_NOTICE |-> busy)
    else $error("expiry notice outside an expire request");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |->
      (cnt_r == $past(cnt_r) + CntW'(1)) || (cnt_r + CntW'(1) == $past(cnt_r)))
    else $error("occupancy moved by more than one");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> cnt_r <= CntW'(tdq_pkg::QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");
`endif

endmodule
